@@ src/fcbg_pkg.sv @@
// ----------------------------------------------------------------------------
// fcbg_pkg
// Shared widths, defaults and register indexes of the four-corner gradient.
// ----------------------------------------------------------------------------
package fcbg_pkg;

  // Default image size.
  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 768;

  // Field widths.
  localparam int COORD_W  = 10;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int COLOR_W  = CHAN_W * NUM_CHAN;

  // Magnitude of a channel difference times a coordinate: 8 x 10 bits.
  localparam int MAG_W   = CHAN_W + COORD_W;
  // Reciprocal of the span, scaled for an exact quotient over MAG_W bits.
  localparam int RECIP_W = MAG_W + 2;
  localparam int MULT_W  = MAG_W + RECIP_W;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_LEFT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_RIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_LEFT     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_RIGHT    = 2'd3;

endpackage

@@ src/fcbg_coord_if.sv @@
// ----------------------------------------------------------------------------
// fcbg_coord_if
// Pixel coordinate channel: valid, ready, column and row.
// ----------------------------------------------------------------------------
interface fcbg_coord_if;
  logic                          valid;
  logic                          ready;
  logic [fcbg_pkg::COORD_W-1:0]  column;
  logic [fcbg_pkg::COORD_W-1:0]  row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

@@ src/fcbg_color_if.sv @@
// ----------------------------------------------------------------------------
// fcbg_color_if
// Pixel color channel: valid, ready and the three 8-bit channels.
// ----------------------------------------------------------------------------
interface fcbg_color_if;
  logic                         valid;
  logic                         ready;
  logic [fcbg_pkg::CHAN_W-1:0]  red;
  logic [fcbg_pkg::CHAN_W-1:0]  green;
  logic [fcbg_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/four_corner_bilinear_gradient.sv @@
// ----------------------------------------------------------------------------
// four_corner_bilinear_gradient
// Throughput: one pixel per cycle while color.ready is high, set by the
// seven-stage pipeline in which each division by a span is a reciprocal
// multiply of its own stage. Each stage holds under back-pressure and fills
// bubbles independently. Reset clears the pipeline valid bits and sets all
// four corner colors to 0.
// ----------------------------------------------------------------------------
module four_corner_bilinear_gradient #(
  parameter int IMAGE_WIDTH  = fcbg_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = fcbg_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fcbg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcbg_pkg::COLOR_W-1:0]     cfg_data,
  fcbg_coord_if.sink                       pixel,
  fcbg_color_if.source                     color
);

  localparam int COORD_W  = fcbg_pkg::COORD_W;
  localparam int CHAN_W   = fcbg_pkg::CHAN_W;
  localparam int NUM_CHAN = fcbg_pkg::NUM_CHAN;
  localparam int COLOR_W  = fcbg_pkg::COLOR_W;
  localparam int MAG_W    = fcbg_pkg::MAG_W;
  localparam int RECIP_W  = fcbg_pkg::RECIP_W;
  localparam int MULT_W   = fcbg_pkg::MULT_W;

  localparam int NUM_STAGES = 7;

  localparam int COL_MAX = IMAGE_WIDTH - 1;
  localparam int ROW_MAX = IMAGE_HEIGHT - 1;

  // Division by a span d is floor(n * m / 2^sh) with m = ceil(2^sh / d) and
  // sh = MAG_W + clog2(d); this is exact for every n below 2^MAG_W.
  localparam int     H_SH      = MAG_W + $clog2(ROW_MAX);
  localparam longint H_RECIP_L = ((longint'(1) << H_SH) + ROW_MAX - 1) / ROW_MAX;
  localparam logic [RECIP_W-1:0] H_RECIP = RECIP_W'(H_RECIP_L);
  localparam int     W_SH      = MAG_W + $clog2(COL_MAX);
  localparam longint W_RECIP_L = ((longint'(1) << W_SH) + COL_MAX - 1) / COL_MAX;
  localparam logic [RECIP_W-1:0] W_RECIP = RECIP_W'(W_RECIP_L);

  // Red sits in the top byte of a packed color.
  function automatic logic [CHAN_W-1:0] chan_of(logic [COLOR_W-1:0] c, int ch);
    return c[COLOR_W - CHAN_W * (ch + 1) +: CHAN_W];
  endfunction

  // Corner color registers.
  logic [COLOR_W-1:0] bottom_left;
  logic [COLOR_W-1:0] bottom_right;
  logic [COLOR_W-1:0] top_left;
  logic [COLOR_W-1:0] top_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_left  <= '0;
      bottom_right <= '0;
      top_left     <= '0;
      top_right    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcbg_pkg::REG_BOTTOM_LEFT:  bottom_left  <= cfg_data;
        fcbg_pkg::REG_BOTTOM_RIGHT: bottom_right <= cfg_data;
        fcbg_pkg::REG_TOP_LEFT:     top_left     <= cfg_data;
        fcbg_pkg::REG_TOP_RIGHT:    top_right    <= cfg_data;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = color.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign pixel.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: clamped coordinates.
  logic [COORD_W-1:0] s0_col;
  logic [COORD_W-1:0] s0_row;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_col <= (int'(pixel.column) > COL_MAX) ? COORD_W'(COL_MAX) : pixel.column;
      s0_row <= (int'(pixel.row) > ROW_MAX) ? COORD_W'(ROW_MAX) : pixel.row;
    end
  end

  // Stage 1: sign and magnitude of (top - bottom) * row on both edges.
  logic               s1_neg_l [NUM_CHAN];
  logic               s1_neg_r [NUM_CHAN];
  logic [MAG_W-1:0]   s1_mag_l [NUM_CHAN];
  logic [MAG_W-1:0]   s1_mag_r [NUM_CHAN];
  logic [COORD_W-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_col <= s0_col;
      for (int c = 0; c < NUM_CHAN; c++) begin
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] t;
        logic [CHAN_W-1:0] d;
        b = chan_of(bottom_left, c);
        t = chan_of(top_left, c);
        d = (t < b) ? b - t : t - b;
        s1_neg_l[c] <= t < b;
        s1_mag_l[c] <= MAG_W'(d) * MAG_W'(s0_row);
        b = chan_of(bottom_right, c);
        t = chan_of(top_right, c);
        d = (t < b) ? b - t : t - b;
        s1_neg_r[c] <= t < b;
        s1_mag_r[c] <= MAG_W'(d) * MAG_W'(s0_row);
      end
    end
  end

  // Stage 2: quotient by the height span.
  logic               s2_neg_l [NUM_CHAN];
  logic               s2_neg_r [NUM_CHAN];
  logic [CHAN_W-1:0]  s2_q_l   [NUM_CHAN];
  logic [CHAN_W-1:0]  s2_q_r   [NUM_CHAN];
  logic [COORD_W-1:0] s2_col;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_col <= s1_col;
      for (int c = 0; c < NUM_CHAN; c++) begin
        logic [MULT_W-1:0] pl;
        logic [MULT_W-1:0] pr;
        pl = MULT_W'(s1_mag_l[c]) * MULT_W'(H_RECIP);
        pr = MULT_W'(s1_mag_r[c]) * MULT_W'(H_RECIP);
        s2_neg_l[c] <= s1_neg_l[c];
        s2_neg_r[c] <= s1_neg_r[c];
        s2_q_l[c]   <= pl[H_SH +: CHAN_W];
        s2_q_r[c]   <= pr[H_SH +: CHAN_W];
      end
    end
  end

  // Stage 3: left and right edge values of the row.
  logic [CHAN_W-1:0]  s3_left  [NUM_CHAN];
  logic [CHAN_W-1:0]  s3_right [NUM_CHAN];
  logic [COORD_W-1:0] s3_col;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_col <= s2_col;
      for (int c = 0; c < NUM_CHAN; c++) begin
        s3_left[c]  <= s2_neg_l[c] ? chan_of(bottom_left, c) - s2_q_l[c]
                                   : chan_of(bottom_left, c) + s2_q_l[c];
        s3_right[c] <= s2_neg_r[c] ? chan_of(bottom_right, c) - s2_q_r[c]
                                   : chan_of(bottom_right, c) + s2_q_r[c];
      end
    end
  end

  // Stage 4: sign and magnitude of (right - left) * column.
  logic              s4_neg  [NUM_CHAN];
  logic [MAG_W-1:0]  s4_mag  [NUM_CHAN];
  logic [CHAN_W-1:0] s4_left [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        logic [CHAN_W-1:0] d;
        d = (s3_right[c] < s3_left[c]) ? s3_left[c] - s3_right[c]
                                       : s3_right[c] - s3_left[c];
        s4_neg[c]  <= s3_right[c] < s3_left[c];
        s4_mag[c]  <= MAG_W'(d) * MAG_W'(s3_col);
        s4_left[c] <= s3_left[c];
      end
    end
  end

  // Stage 5: quotient by the width span.
  logic              s5_neg  [NUM_CHAN];
  logic [CHAN_W-1:0] s5_q    [NUM_CHAN];
  logic [CHAN_W-1:0] s5_left [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        logic [MULT_W-1:0] p;
        p = MULT_W'(s4_mag[c]) * MULT_W'(W_RECIP);
        s5_neg[c]  <= s4_neg[c];
        s5_q[c]    <= p[W_SH +: CHAN_W];
        s5_left[c] <= s4_left[c];
      end
    end
  end

  // Stage 6: pixel value, held here until the transfer on the color channel.
  logic [CHAN_W-1:0] s6_val [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        s6_val[c] <= s5_neg[c] ? s5_left[c] - s5_q[c] : s5_left[c] + s5_q[c];
      end
    end
  end

  assign color.valid = vld[NUM_STAGES-1];
  assign color.red   = s6_val[0];
  assign color.green = s6_val[1];
  assign color.blue  = s6_val[2];

endmodule
